// ----- sv/cle_pkg.sv -----
package cle_pkg;

  localparam int LINE_MAX = 64;
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int CNT_W    = $clog2(LINE_MAX + 1);

  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_TAB   = 8'h09;
  localparam logic [7:0] KEY_CR    = 8'h0D;
  localparam logic [7:0] KEY_KILL  = 8'h15;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] KEY_DEL   = 8'h7F;
  localparam logic [7:0] KEY_LC_A  = 8'h61;
  localparam logic [7:0] KEY_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  typedef enum logic [2:0] {
    EK_NONE    = 3'd0,
    EK_CHAR    = 3'd1,
    EK_BELL    = 3'd2,
    EK_ERASE   = 3'd3,
    EK_NEWLINE = 3'd4
  } echo_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERASE,
    ST_EMIT,
    ST_LINE
  } ctrl_state_e;

  typedef struct packed {
    echo_kind_e        echo_kind;
    logic [7:0]        echo_char;
    logic [7:0]        erase_units;
    logic              line_valid;
    logic [7:0]        line_char;
    logic              line_last;
    logic [CNT_W-1:0]  line_length;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } push_t;

  // screen cells needed to rub out one stored byte
  function automatic logic [1:0] units_of(input logic [7:0] b);
    return (b < KEY_SPACE || b[7]) ? 2'd2 : 2'd1;
  endfunction

endpackage

// ----- sv/console_line_editor.sv -----
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   key_char_i
// out      output     out_valid_o / out_stall_i echo_kind_o .. line_length_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (keep typed case)
//
// A plain key, kill or erase on an empty line goes from idle to the emit state;
// an erase first passes the erase state to read the last character from the store.
// Carriage return sends a line of n characters, one character per cycle while the
// output is not stalled, from the single read port of the store.
// Reset clears the count, erase total and output valid flag; the store is left as is.
// An output stall holds the result register; the next key is still taken while
// one result waits.
module console_line_editor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                key_char_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                echo_kind_o,
  output logic [7:0]                echo_char_o,
  output logic [7:0]                erase_units_o,
  output logic                      line_valid_o,
  output logic [7:0]                line_char_o,
  output logic                      line_last_o,
  output logic [cle_pkg::CNT_W-1:0] line_length_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_data_i
);

  logic             case_keep_q;
  logic             out_valid_q;
  cle_pkg::result_t out_q;
  cle_pkg::push_t   push;
  logic             out_free;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  cle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_char_i  (key_char_i),
    .case_keep_i (case_keep_q),
    .out_free_i  (out_free),
    .push_o      (push)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_keep_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case_keep_q <= cfg_data_i;
      end
      if (push.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.push) begin
      out_q <= push.res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign echo_kind_o   = out_q.echo_kind;
  assign echo_char_o   = out_q.echo_char;
  assign erase_units_o = out_q.erase_units;
  assign line_valid_o  = out_q.line_valid;
  assign line_char_o   = out_q.line_char;
  assign line_last_o   = out_q.line_last;
  assign line_length_o = out_q.line_length;

endmodule

// ----- sv/cle_line_ram.sv -----
module cle_line_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [cle_pkg::ADDR_W-1:0] waddr_i,
  input  logic [7:0]                wdata_i,
  input  logic [cle_pkg::ADDR_W-1:0] raddr_i,
  output logic [7:0]                rdata_o
);

  logic [7:0] mem [cle_pkg::LINE_MAX];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/cle_ctrl.sv -----
module cle_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     key_char_i,
  input  logic           case_keep_i,
  input  logic           out_free_i,
  output cle_pkg::push_t push_o
);

  cle_pkg::ctrl_state_e state_q, state_d;
  logic [cle_pkg::CNT_W-1:0]  count_q, count_d;
  logic [7:0]                 erase_q, erase_d;
  logic [cle_pkg::ADDR_W-1:0] idx_q, idx_d;
  cle_pkg::result_t           res_q, res_d, res;

  logic                       we;
  logic [cle_pkg::ADDR_W-1:0] raddr;
  logic [7:0]                 rdata;
  logic [7:0]                 key_eff;
  logic [7:0]                 stored;
  logic [1:0]                 u_new;
  logic [1:0]                 u_old;
  logic [cle_pkg::CNT_W-1:0]  cnt_m1;
  logic                       push;
  logic                       last;

  cle_line_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[cle_pkg::ADDR_W-1:0]),
    .wdata_i (stored),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign key_eff = (key_char_i == cle_pkg::KEY_TAB) ? cle_pkg::KEY_SPACE : key_char_i;
  assign stored  = (!case_keep_i && key_eff >= cle_pkg::KEY_LC_A &&
                    key_eff <= cle_pkg::KEY_LC_Z) ? key_eff - cle_pkg::CASE_OFS : key_eff;
  assign u_new   = cle_pkg::units_of(stored);
  assign u_old   = cle_pkg::units_of(rdata);
  assign cnt_m1  = count_q - cle_pkg::CNT_W'(1);
  assign last    = ({1'b0, idx_q} == cnt_m1);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    erase_d    = erase_q;
    idx_d      = idx_q;
    res_d      = res_q;
    res        = res_q;
    we         = 1'b0;
    raddr      = idx_q;
    push       = 1'b0;
    in_stall_o = 1'b1;

    unique case (state_q)
      cle_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        res_d      = '0;
        if (in_valid_i) begin
          priority if (key_char_i == cle_pkg::KEY_CR) begin
            if (count_q == '0) begin
              res_d.echo_kind  = cle_pkg::EK_NEWLINE;
              res_d.line_valid = 1'b1;
              res_d.line_last  = 1'b1;
              state_d          = cle_pkg::ST_EMIT;
            end else begin
              raddr   = '0;
              idx_d   = '0;
              state_d = cle_pkg::ST_LINE;
            end
          end else if (key_char_i == cle_pkg::KEY_BS || key_char_i == cle_pkg::KEY_DEL) begin
            if (count_q == '0) begin
              res_d.echo_kind = cle_pkg::EK_BELL;
              state_d         = cle_pkg::ST_EMIT;
            end else begin
              // fetch the last character to size its rubout
              raddr   = cnt_m1[cle_pkg::ADDR_W-1:0];
              state_d = cle_pkg::ST_ERASE;
            end
          end else if (key_char_i == cle_pkg::KEY_KILL) begin
            res_d.echo_kind   = cle_pkg::EK_ERASE;
            res_d.erase_units = erase_q;
            count_d           = '0;
            erase_d           = '0;
            state_d           = cle_pkg::ST_EMIT;
          end else if (count_q < cle_pkg::CNT_W'(cle_pkg::LINE_MAX)) begin
            we              = 1'b1;
            count_d         = count_q + cle_pkg::CNT_W'(1);
            erase_d         = erase_q + {6'd0, u_new};
            res_d.echo_kind = cle_pkg::EK_CHAR;
            res_d.echo_char = key_eff;
            state_d         = cle_pkg::ST_EMIT;
          end else begin
            res_d.echo_kind = cle_pkg::EK_BELL;
            state_d         = cle_pkg::ST_EMIT;
          end
        end
      end

      cle_pkg::ST_ERASE: begin
        count_d           = cnt_m1;
        erase_d           = (erase_q >= {6'd0, u_old}) ? erase_q - {6'd0, u_old} : 8'd0;
        res_d.echo_kind   = cle_pkg::EK_ERASE;
        res_d.erase_units = {6'd0, u_old};
        state_d           = cle_pkg::ST_EMIT;
      end

      cle_pkg::ST_EMIT: begin
        if (out_free_i) begin
          push    = 1'b1;
          state_d = cle_pkg::ST_IDLE;
        end
      end

      cle_pkg::ST_LINE: begin
        res             = '0;
        res.echo_kind   = (idx_q == '0) ? cle_pkg::EK_NEWLINE : cle_pkg::EK_NONE;
        res.line_valid  = 1'b1;
        res.line_char   = rdata;
        res.line_last   = last;
        res.line_length = count_q;
        if (out_free_i) begin
          push  = 1'b1;
          // prefetch the next entry; otherwise hold the current one
          raddr = idx_q + cle_pkg::ADDR_W'(1);
          idx_d = idx_q + cle_pkg::ADDR_W'(1);
          if (last) begin
            count_d = '0;
            erase_d = '0;
            state_d = cle_pkg::ST_IDLE;
          end
        end
      end

      default: state_d = cle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cle_pkg::ST_IDLE;
      count_q <= '0;
      erase_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      erase_q <= erase_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign push_o.push = push;
  assign push_o.res  = res;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cle_pkg::CNT_W'(cle_pkg::LINE_MAX))
    else $error("line count beyond capacity");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free_i)
    else $error("result pushed into a full output register");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res.line_last |=> count_q == '0 && state_q == cle_pkg::ST_IDLE)
    else $error("line not cleared after its last character");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> state_q == cle_pkg::ST_EMIT)
    else $error("store write outside an accepted character");
`endif

endmodule
